FILE: rtl/mhpq_pkg.sv
// Shared constants, command and status types for the min-heap priority queue.
`default_nettype none

package mhpq_pkg;

   // Key and result field widths, and the default capacity
   localparam int KEY_W            = 32;
   localparam int STATUS_W         = 2;
   localparam int HELD_W           = 8;
   localparam int CAPACITY_DEFAULT = 128;

   // Request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Datapath operation codes
   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_INS_ROOT  = 4'd1;
   localparam logic [3:0] OP_INS_BEGIN = 4'd2;
   localparam logic [3:0] OP_UP_MOVE   = 4'd3;
   localparam logic [3:0] OP_PUT_V     = 4'd4;
   localparam logic [3:0] OP_RM_BEGIN  = 4'd5;
   localparam logic [3:0] OP_RM_ROOT   = 4'd6;
   localparam logic [3:0] OP_RM_LAST   = 4'd7;
   localparam logic [3:0] OP_DN_LEFT   = 4'd8;
   localparam logic [3:0] OP_DN_MOVE   = 4'd9;
   localparam logic [3:0] OP_RESULT    = 4'd10;

   // Controller to datapath
   typedef struct packed {
      logic [3:0]          op;
      logic                pick;   // right child key is present in the read register
      logic [STATUS_W-1:0] code;   // status code for the result word
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cnt_zero;
      logic cnt_full;
      logic up_less;      // sifting key below its parent
      logic up_top;       // parent of the current position is the root
      logic c_le_n;       // left child exists
      logic c_lt_n;       // right child exists
      logic child_less;   // chosen child below the sifting key
      logic next_c_le_n;  // chosen child has a child of its own
      logic rsp_busy;     // result register full and not taken this cycle
   } stat_type;

endpackage

`default_nettype wire

FILE: rtl/mhpq_ctrl.sv
// Sequencing state machine for the min-heap priority queue.
`default_nettype none

module mhpq_ctrl
   import mhpq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     req_kind,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UP      = 3'd1;
   localparam logic [2:0] S_PUT     = 3'd2;
   localparam logic [2:0] S_RM_ROOT = 3'd3;
   localparam logic [2:0] S_RM_LAST = 3'd4;
   localparam logic [2:0] S_DN_L    = 3'd5;
   localparam logic [2:0] S_DN_R    = 3'd6;
   localparam logic [2:0] S_FINISH  = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;

   // Decide the next state and this cycle's datapath operation
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd.op    = OP_NONE;
      cmd.pick  = (state_ff == S_DN_R);
      cmd.code  = code_ff;
      req_ready = (state_ff == S_IDLE) && !reset;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               code_in = ST_DONE;
               if (req_kind == KIND_INSERT) begin
                  if (stat.cnt_full) begin
                     code_in  = ST_FULL;
                     state_in = S_FINISH;
                  end else if (stat.cnt_zero) begin
                     cmd.op   = OP_INS_ROOT;
                     state_in = S_FINISH;
                  end else begin
                     cmd.op   = OP_INS_BEGIN;
                     state_in = S_UP;
                  end
               end else begin
                  if (stat.cnt_zero) begin
                     code_in  = ST_EMPTY;
                     state_in = S_FINISH;
                  end else begin
                     cmd.op   = OP_RM_BEGIN;
                     state_in = S_RM_ROOT;
                  end
               end
            end
         end
         S_UP: begin
            if (stat.up_less) begin
               cmd.op   = OP_UP_MOVE;
               state_in = stat.up_top ? S_PUT : S_UP;
            end else begin
               cmd.op   = OP_PUT_V;
               state_in = S_FINISH;
            end
         end
         S_PUT: begin
            cmd.op   = OP_PUT_V;
            state_in = S_FINISH;
         end
         S_RM_ROOT: begin
            cmd.op   = OP_RM_ROOT;
            state_in = S_RM_LAST;
         end
         S_RM_LAST: begin
            cmd.op = OP_RM_LAST;
            if (stat.cnt_zero) begin
               state_in = S_FINISH;
            end else if (!stat.c_le_n) begin
               state_in = S_PUT;
            end else begin
               state_in = S_DN_L;
            end
         end
         S_DN_L: begin
            if (stat.c_lt_n) begin
               cmd.op   = OP_DN_LEFT;
               state_in = S_DN_R;
            end else if (stat.child_less) begin
               cmd.op   = OP_DN_MOVE;
               state_in = stat.next_c_le_n ? S_DN_L : S_PUT;
            end else begin
               cmd.op   = OP_PUT_V;
               state_in = S_FINISH;
            end
         end
         S_DN_R: begin
            if (stat.child_less) begin
               cmd.op   = OP_DN_MOVE;
               state_in = stat.next_c_le_n ? S_DN_L : S_PUT;
            end else begin
               cmd.op   = OP_PUT_V;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.op   = OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and pending status code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mhpq_dp.sv
// Heap store, sift registers and result register of the min-heap priority queue.
`default_nettype none

module mhpq_dp
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   input  wire logic signed [KEY_W-1:0] req_key,
   output stat_type                     stat,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic signed [KEY_W-1:0]      rsp_min_key,
   output logic [HELD_W-1:0]            rsp_entries_held
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = PW + 1;

   // Store address of a one-based heap position
   function automatic logic [AW-1:0] pos_addr(input logic [CW-1:0] p);
      logic [CW-1:0] a;
      a = p - CW'(1);
      return a[AW-1:0];
   endfunction

   logic signed [KEY_W-1:0] mem [CAPACITY];

   logic [PW-1:0]           cnt_ff, cnt_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [CW-1:0]           c_ff, c_in;
   logic signed [KEY_W-1:0] v_ff, v_in;
   logic signed [KEY_W-1:0] lkey_ff, lkey_in;
   logic signed [KEY_W-1:0] min_ff, min_in;
   logic signed [KEY_W-1:0] rdata_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic signed [KEY_W-1:0] rsp_min_ff;
   logic [HELD_W-1:0]       rsp_held_ff;

   logic                    we, re;
   logic [AW-1:0]           waddr, raddr;
   logic signed [KEY_W-1:0] wdata;

   logic [PW-1:0]           cnt_inc, pos_half;
   logic                    sel_right;
   logic signed [KEY_W-1:0] child_key;
   logic [CW-1:0]           child_pos, next_c, cnt_wide;
   logic [31:0]             cnt32;

   // Compare and select for the sift steps
   always_comb begin
      cnt_inc   = cnt_ff + PW'(1);
      pos_half  = pos_ff >> 1;
      cnt_wide  = CW'(cnt_ff);
      sel_right = cmd.pick && (rdata_ff < lkey_ff);
      child_key = (cmd.pick && !sel_right) ? lkey_ff : rdata_ff;
      child_pos = c_ff + CW'(sel_right);
      next_c    = {child_pos[PW-1:0], 1'b0};
      cnt32     = 32'(cnt_ff);
   end

   always_comb begin
      stat.cnt_zero    = (cnt_ff == '0);
      stat.cnt_full    = (cnt_ff == PW'(CAPACITY));
      stat.up_less     = (v_ff < rdata_ff);
      stat.up_top      = (pos_half == PW'(1));
      stat.c_le_n      = (c_ff <= cnt_wide);
      stat.c_lt_n      = (c_ff < cnt_wide);
      stat.child_less  = (child_key < v_ff);
      stat.next_c_le_n = (next_c <= cnt_wide);
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   // Decode the operation into store accesses and register updates
   always_comb begin
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      c_in    = c_ff;
      v_in    = v_ff;
      lkey_in = lkey_ff;
      min_in  = min_ff;
      we      = 1'b0;
      re      = 1'b0;
      waddr   = pos_addr(CW'(pos_ff));
      raddr   = '0;
      wdata   = v_ff;
      unique case (cmd.op)
         OP_INS_ROOT: begin
            we     = 1'b1;
            waddr  = '0;
            wdata  = req_key;
            cnt_in = cnt_inc;
            min_in = '0;
         end
         OP_INS_BEGIN: begin
            v_in   = req_key;
            cnt_in = cnt_inc;
            pos_in = cnt_inc;
            min_in = '0;
            re     = 1'b1;
            raddr  = pos_addr(CW'(cnt_inc >> 1));
         end
         OP_UP_MOVE: begin
            we     = 1'b1;
            wdata  = rdata_ff;
            pos_in = pos_half;
            re     = !stat.up_top;
            raddr  = pos_addr(CW'(pos_half >> 1));
         end
         OP_PUT_V: begin
            we = 1'b1;
         end
         OP_RM_BEGIN: begin
            re = 1'b1;
         end
         OP_RM_ROOT: begin
            min_in = rdata_ff;
            cnt_in = cnt_ff - PW'(1);
            re     = 1'b1;
            raddr  = pos_addr(cnt_wide);
            pos_in = PW'(1);
            c_in   = CW'(2);
         end
         OP_RM_LAST: begin
            v_in  = rdata_ff;
            re    = stat.c_le_n;
            raddr = pos_addr(c_ff);
         end
         OP_DN_LEFT: begin
            lkey_in = rdata_ff;
            re      = 1'b1;
            raddr   = pos_addr(c_ff + CW'(1));
         end
         OP_DN_MOVE: begin
            we     = 1'b1;
            wdata  = child_key;
            pos_in = child_pos[PW-1:0];
            c_in   = next_c;
            re     = stat.next_c_le_n;
            raddr  = pos_addr(next_c);
         end
         default: begin
         end
      endcase
   end

   // Heap store with registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // Advance the sift registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      pos_ff  <= pos_in;
      c_ff    <= c_in;
      v_ff    <= v_in;
      lkey_ff <= lkey_in;
      min_ff  <= min_in;
   end

   // Load the result word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_RESULT) begin
         rsp_status_ff <= cmd.code;
         rsp_min_ff    <= (cmd.code == ST_DONE) ? min_ff : '0;
         rsp_held_ff   <= cnt32[HELD_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_min_key      = rsp_min_ff;
   assign rsp_entries_held = rsp_held_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= PW'(CAPACITY))
      else $error("entry count above capacity");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESULT |=> rsp_valid_ff)
      else $error("result word not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_RESULT |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result word overwritten while stalled");

   a_cnt_stable: assert property (@(posedge clock) disable iff (reset)
      (cmd.op != OP_INS_ROOT && cmd.op != OP_INS_BEGIN && cmd.op != OP_RM_ROOT)
      |=> $stable(cnt_ff))
      else $error("entry count changed outside insert or remove");

endmodule

`default_nettype wire

FILE: rtl/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: controller and datapath.
//
// Requests arrive on req_*: tuser bit 0 selects insert (0) or remove-min (1),
// tdata carries the signed 32-bit key (ignored for a remove). Every request
// gives exactly one result word on rsp_*: status (0 done, 1 remove from empty,
// 2 insert into full), the removed key (zero unless a remove succeeded) and
// the number of keys held afterwards (low 8 bits).
// One request is worked at a time; req_tready is high only while idle and
// out of reset.
// An insert climbs the key by L levels (one store read, compare and write
// per level); a remove sinks the last key by D levels (up to two child reads
// per level through the single read port). Errors and an insert into an
// empty heap go straight to the result word.
// The next request can be taken in the cycle that the result word appears.
// Reset empties the heap at once; the key store itself is not cleared.
// A stalled result waits in an output register; the block finishes the next
// item meanwhile and holds it until the output register frees.
`default_nettype none

module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] key
   input  wire logic [0:0]  req_tuser,   // [0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // [1:0] status, [33:2] min_key,
                                         // [41:34] entries_held, [47:42] zero
);

   cmd_type                 cmd;
   stat_type                stat;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [KEY_W-1:0] rsp_min_key;
   logic [HELD_W-1:0]       rsp_entries_held;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser[0]),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_key          (req_tdata),
      .stat             (stat),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_status       (rsp_status),
      .rsp_min_key      (rsp_min_key),
      .rsp_entries_held (rsp_entries_held)
   );

   // Pack the result word
   assign rsp_tdata = {6'd0, rsp_entries_held, rsp_min_key, rsp_status};

endmodule

`default_nettype wire
